// ----- rtl/core/compass_heading_to_seven_segment_assert.svh -----
// ----------------------------------------------------------------------------
// Compass heading assertion macros
// Shared concurrent assertion forms for the heading block checkers.
// ----------------------------------------------------------------------------
`ifndef COMPASS_HEADING_TO_SEVEN_SEGMENT_ASSERT_SVH
`define COMPASS_HEADING_TO_SEVEN_SEGMENT_ASSERT_SVH

// clocked property, masked while reset is asserted
`define CHSS_ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked property that holds in and out of reset
`define CHSS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/core/chss_pkg.sv -----
// ----------------------------------------------------------------------------
// chss_pkg
// Types and constant tables for the compass heading block.
// ----------------------------------------------------------------------------
`default_nettype none

package chss_pkg;

  localparam int SAMPLE_W = 16;
  localparam int FRAC_W   = 16;
  localparam int XW       = 36;   // CORDIC x/y datapath width
  localparam int ZW       = 27;   // angle accumulator, degrees Q16
  localparam int HEAD_W   = 9;
  localparam int TABLE_LEN = 24;

  localparam logic [SAMPLE_W-1:0] Y_OFFSET_RST = 16'd500;

  localparam logic [HEAD_W-1:0] DEG_0   = 9'd0;
  localparam logic [HEAD_W-1:0] DEG_90  = 9'd90;
  localparam logic [HEAD_W-1:0] DEG_179 = 9'd179;
  localparam logic [HEAD_W-1:0] DEG_180 = 9'd180;
  localparam logic [HEAD_W-1:0] DEG_270 = 9'd270;
  localparam logic [HEAD_W-1:0] DEG_359 = 9'd359;

  localparam logic signed [ZW-1:0] Z_PLUS_90  = 27'sd5898240;
  localparam logic signed [ZW-1:0] Z_MINUS_90 = -27'sd5898240;
  localparam logic signed [ZW-1:0] Z_360      = 27'sd23592960;

  localparam logic signed [ZW-1:0] ATAN_DEG_Q16 [TABLE_LEN] = '{
    27'sd2949120, 27'sd1740967, 27'sd919879, 27'sd466945,
    27'sd234379,  27'sd117304,  27'sd58666,  27'sd29335,
    27'sd14668,   27'sd7334,    27'sd3667,   27'sd1833,
    27'sd917,     27'sd458,     27'sd229,    27'sd115,
    27'sd57,      27'sd29,      27'sd14,     27'sd7,
    27'sd4,       27'sd2,       27'sd1,      27'sd0
  };

  localparam logic [6:0] SEG_TABLE [10] = '{
    7'h40, 7'h79, 7'h24, 7'h30, 7'h19, 7'h12, 7'h02, 7'h78, 7'h00, 7'h10
  };

  typedef struct packed {
    logic                  valid;
    logic                  axis;      // exact axis case, heading in axis_deg
    logic [HEAD_W-1:0]     axis_deg;
    logic                  y_pos;
    logic signed [XW-1:0]  cx;
    logic signed [XW-1:0]  cy;
    logic signed [ZW-1:0]  z;
  } chss_vec_t;

endpackage

`default_nettype wire

// ----- rtl/core/chss_if.sv -----
// ----------------------------------------------------------------------------
// chss interfaces
// Valid/ready channels for samples, results and the offset register write.
// ----------------------------------------------------------------------------
`default_nettype none

interface chss_in_if;
  logic                        valid;
  logic                        ready;
  logic signed [15:0]          x_sample;
  logic signed [15:0]          y_sample;
  modport source (output valid, output x_sample, output y_sample, input ready);
  modport sink   (input valid, input x_sample, input y_sample, output ready);
endinterface

interface chss_out_if;
  logic       valid;
  logic       ready;
  logic [8:0] heading_degrees;
  logic [1:0] hundreds_digit;
  logic [3:0] tens_digit;
  logic [3:0] ones_digit;
  logic [6:0] segment_pins;
  modport source (output valid, output heading_degrees, output hundreds_digit,
                  output tens_digit, output ones_digit, output segment_pins,
                  input ready);
  modport sink   (input valid, input heading_degrees, input hundreds_digit,
                  input tens_digit, input ones_digit, input segment_pins,
                  output ready);
endinterface

interface chss_cfg_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/chss_cordic_stage.sv -----
// ----------------------------------------------------------------------------
// chss_cordic_stage
// One registered vectoring CORDIC micro-rotation at a fixed step index.
// ----------------------------------------------------------------------------
`default_nettype none

module chss_cordic_stage #(
  parameter int STEP = 0
) (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 en,
  input  chss_pkg::chss_vec_t vec_i,
  output chss_pkg::chss_vec_t vec_o
);

  chss_pkg::chss_vec_t vec_r;
  chss_pkg::chss_vec_t vec_nxt;
  logic signed [chss_pkg::XW-1:0] sx;
  logic signed [chss_pkg::XW-1:0] sy;

  always_comb begin
    sx      = vec_i.cx >>> STEP;
    sy      = vec_i.cy >>> STEP;
    vec_nxt = vec_i;
    if (vec_i.cy >= 0) begin
      vec_nxt.cx = vec_i.cx + sy;
      vec_nxt.cy = vec_i.cy - sx;
      vec_nxt.z  = vec_i.z + chss_pkg::ATAN_DEG_Q16[STEP];
    end else begin
      vec_nxt.cx = vec_i.cx - sy;
      vec_nxt.cy = vec_i.cy + sx;
      vec_nxt.z  = vec_i.z - chss_pkg::ATAN_DEG_Q16[STEP];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vec_r.valid <= 1'b0;
    end else if (en) begin
      vec_r <= vec_nxt;
    end
  end

  assign vec_o = vec_r;

endmodule

`default_nettype wire

// ----- rtl/core/compass_heading_to_seven_segment.sv -----
// ----------------------------------------------------------------------------
// compass_heading_to_seven_segment
// Pipelined CORDIC atan2 compass heading with decimal digits and segments.
//
//   channel   dir  payload                                        handshake
//   in_chan   in   x_sample, y_sample (s16)                       valid/ready
//   out_chan  out  heading_degrees, 3 digits, segment_pins        valid/ready
//   cfg_chan  in   data = y_offset (s16), always ready            valid/ready
//
// One sample per cycle while out_chan is not stalled; registered stages are the
// input stage, one stage per CORDIC step, the heading stage and the digit stage.
// rst_n clears stage valid bits and loads y_offset with 500.
// The whole pipeline holds while a result waits on out_chan.ready.
// ----------------------------------------------------------------------------
`default_nettype none

module compass_heading_to_seven_segment #(
  parameter int CORDIC_STEPS = 16
) (
  input  wire        clk,
  input  wire        rst_n,
  chss_in_if.sink    in_chan,
  chss_out_if.source out_chan,
  chss_cfg_if.sink   cfg_chan
);

  logic                           adv;
  logic signed [15:0]             y_offset_r;
  logic signed [15:0]             ysum;
  logic signed [15:0]             xs;
  chss_pkg::chss_vec_t            vec0_nxt;
  chss_pkg::chss_vec_t            stg0_r;
  chss_pkg::chss_vec_t            stg [CORDIC_STEPS+1];
  chss_pkg::chss_vec_t            fin;

  logic                           hv_r;
  logic [chss_pkg::HEAD_W-1:0]    h_r;
  logic [chss_pkg::HEAD_W-1:0]    h_nxt;
  logic signed [chss_pkg::ZW-1:0] zw;
  logic signed [10:0]             hq;

  logic                           ov_r;
  logic [8:0]                     head_r;
  logic [1:0]                     hund_r;
  logic [3:0]                     tens_r;
  logic [3:0]                     ones_r;
  logic [6:0]                     seg_r;
  logic [1:0]                     hund_nxt;
  logic [6:0]                     rem;
  logic [14:0]                    prod;
  logic [3:0]                     tens_nxt;
  logic [3:0]                     ones_nxt;

  assign adv          = !ov_r || out_chan.ready;
  assign in_chan.ready = adv;
  assign cfg_chan.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      y_offset_r <= chss_pkg::Y_OFFSET_RST;
    end else if (cfg_chan.valid) begin
      y_offset_r <= cfg_chan.data;
    end
  end

  // input stage: offset, axis cases, quadrant pre-rotation
  always_comb begin
    xs   = in_chan.x_sample;
    ysum = in_chan.y_sample + y_offset_r;
    vec0_nxt.valid    = in_chan.valid;
    vec0_nxt.axis     = (ysum == 16'sd0) || (xs == 16'sd0);
    vec0_nxt.y_pos    = ysum > 16'sd0;
    vec0_nxt.axis_deg = chss_pkg::DEG_0;
    if (ysum == 16'sd0) begin
      vec0_nxt.axis_deg = (xs < 16'sd0) ? chss_pkg::DEG_180 : chss_pkg::DEG_0;
    end else if (xs == 16'sd0) begin
      vec0_nxt.axis_deg = (ysum > 16'sd0) ? chss_pkg::DEG_90 : chss_pkg::DEG_270;
    end
    vec0_nxt.cx = {{(chss_pkg::XW-chss_pkg::SAMPLE_W-chss_pkg::FRAC_W){xs[15]}},
                   xs, {chss_pkg::FRAC_W{1'b0}}};
    vec0_nxt.cy = {{(chss_pkg::XW-chss_pkg::SAMPLE_W-chss_pkg::FRAC_W){ysum[15]}},
                   ysum, {chss_pkg::FRAC_W{1'b0}}};
    vec0_nxt.z  = '0;
    if (xs < 16'sd0) begin
      if (ysum > 16'sd0) begin
        vec0_nxt.cx = {{(chss_pkg::XW-chss_pkg::SAMPLE_W-chss_pkg::FRAC_W){ysum[15]}},
                       ysum, {chss_pkg::FRAC_W{1'b0}}};
        vec0_nxt.cy = -{{(chss_pkg::XW-chss_pkg::SAMPLE_W-chss_pkg::FRAC_W){xs[15]}},
                        xs, {chss_pkg::FRAC_W{1'b0}}};
        vec0_nxt.z  = chss_pkg::Z_PLUS_90;
      end else begin
        vec0_nxt.cx = -{{(chss_pkg::XW-chss_pkg::SAMPLE_W-chss_pkg::FRAC_W){ysum[15]}},
                        ysum, {chss_pkg::FRAC_W{1'b0}}};
        vec0_nxt.cy = {{(chss_pkg::XW-chss_pkg::SAMPLE_W-chss_pkg::FRAC_W){xs[15]}},
                       xs, {chss_pkg::FRAC_W{1'b0}}};
        vec0_nxt.z  = chss_pkg::Z_MINUS_90;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg0_r.valid <= 1'b0;
    end else if (adv) begin
      stg0_r <= vec0_nxt;
    end
  end

  assign stg[0] = stg0_r;

  for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_step
    chss_cordic_stage #(
      .STEP (k)
    ) u_stage (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (adv),
      .vec_i (stg[k]),
      .vec_o (stg[k+1])
    );
  end

  assign fin = stg[CORDIC_STEPS];

  // heading stage: floor, wrap lower half, clamp
  always_comb begin
    zw    = fin.y_pos ? fin.z : (fin.z + chss_pkg::Z_360);
    hq    = zw[chss_pkg::ZW-1:chss_pkg::FRAC_W];
    h_nxt = hq[8:0];
    if (fin.axis) begin
      h_nxt = fin.axis_deg;
    end else if (fin.y_pos) begin
      if (hq < 11'sd0) begin
        h_nxt = chss_pkg::DEG_0;
      end else if (hq > 11'sd179) begin
        h_nxt = chss_pkg::DEG_179;
      end
    end else begin
      if (hq < 11'sd180) begin
        h_nxt = chss_pkg::DEG_180;
      end else if (hq > 11'sd359) begin
        h_nxt = chss_pkg::DEG_359;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hv_r <= 1'b0;
    end else if (adv) begin
      hv_r <= fin.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      h_r <= h_nxt;
    end
  end

  // digit stage: tens by reciprocal multiply (205 / 2048, exact below 100)
  always_comb begin
    if (h_r >= 9'd300) begin
      hund_nxt = 2'd3;
      rem      = 7'(h_r - 9'd300);
    end else if (h_r >= 9'd200) begin
      hund_nxt = 2'd2;
      rem      = 7'(h_r - 9'd200);
    end else if (h_r >= 9'd100) begin
      hund_nxt = 2'd1;
      rem      = 7'(h_r - 9'd100);
    end else begin
      hund_nxt = 2'd0;
      rem      = h_r[6:0];
    end
    prod     = {8'd0, rem} * 15'd205;
    tens_nxt = prod[14:11];
    ones_nxt = 4'(rem - 7'(tens_nxt) * 7'd10);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else if (adv) begin
      ov_r <= hv_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      head_r <= h_r;
      hund_r <= hund_nxt;
      tens_r <= tens_nxt;
      ones_r <= ones_nxt;
      seg_r  <= chss_pkg::SEG_TABLE[ones_nxt];
    end
  end

  assign out_chan.valid           = ov_r;
  assign out_chan.heading_degrees = head_r;
  assign out_chan.hundreds_digit  = hund_r;
  assign out_chan.tens_digit      = tens_r;
  assign out_chan.ones_digit      = ones_r;
  assign out_chan.segment_pins    = seg_r;

endmodule

`default_nettype wire

// ----- rtl/core/chss_checker.sv -----
// ----------------------------------------------------------------------------
// chss_checker
// Port-level checks on the heading result channel, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "compass_heading_to_seven_segment_assert.svh"

module chss_checker (
  input wire       clk,
  input wire       rst_n,
  input wire       out_valid,
  input wire       out_ready,
  input wire [8:0] heading_degrees,
  input wire [1:0] hundreds_digit,
  input wire [3:0] tens_digit,
  input wire [3:0] ones_digit,
  input wire [6:0] segment_pins
);

  `CHSS_ASSERT_CLK(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid, "result dropped while stalled")
  `CHSS_ASSERT_CLK(a_range, clk, rst_n, out_valid |-> heading_degrees <= 9'd359, "heading out of range")
  `CHSS_ASSERT_CLK(a_digits, clk, rst_n, out_valid |-> (10'(hundreds_digit) * 10'd100 + 10'(tens_digit) * 10'd10 + 10'(ones_digit)) == 10'(heading_degrees), "digits disagree with heading")
  `CHSS_ASSERT_CLK(a_segs, clk, rst_n, out_valid |-> (ones_digit <= 4'd9) && (segment_pins == chss_pkg::SEG_TABLE[ones_digit]), "segments disagree with ones digit")

endmodule

bind compass_heading_to_seven_segment chss_checker u_chss_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_chan.valid),
  .out_ready       (out_chan.ready),
  .heading_degrees (out_chan.heading_degrees),
  .hundreds_digit  (out_chan.hundreds_digit),
  .tens_digit      (out_chan.tens_digit),
  .ones_digit      (out_chan.ones_digit),
  .segment_pins    (out_chan.segment_pins)
);

`default_nettype wire

// ----- tb/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the CORDIC compass heading block: directed and random X/Y
// samples under several Y offsets, with predicted heading, digits and
// segment patterns checked in order against each result, under random
// source gaps and sink stalls.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CORDIC_STEPS = 16;
  localparam int LATENCY      = CORDIC_STEPS + 3;
  localparam int LIMIT_CYCLES = 400000;
  localparam int RANDOM_ITEMS = 1300;
  localparam int N_PHASES     = 6;

  typedef struct {
    logic signed [15:0] x;
    logic signed [15:0] y;
    int unsigned        gap;
  } sample_req_t;

  typedef struct packed {
    logic [8:0] heading;
    logic [1:0] hundreds;
    logic [3:0] tens;
    logic [3:0] ones;
    logic [6:0] segs;
  } heading_t;

  localparam longint ATAN_Q16 [24] = '{
    2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
    14668, 7334, 3667, 1833, 917, 458, 229, 115,
    57, 29, 14, 7, 4, 2, 1, 0
  };

  localparam logic [6:0] SEGS_LOW [10] = '{
    7'h40, 7'h79, 7'h24, 7'h30, 7'h19, 7'h12, 7'h02, 7'h78, 7'h00, 7'h10
  };

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  chss_in_if  in_chan ();
  chss_out_if out_chan ();
  chss_cfg_if cfg_chan ();

  compass_heading_to_seven_segment #(
    .CORDIC_STEPS(CORDIC_STEPS)
  ) i_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_chan),
    .out_chan(out_chan),
    .cfg_chan(cfg_chan)
  );

  always #5 clk = ~clk;

  sample_req_t        sample_q[$];
  heading_t           heading_q[$];
  sample_req_t        cur_req;
  logic signed [15:0] y_off = 16'sd500;
  int                 idle_cnt;
  int                 stall_left;
  int                 n_results;
  int                 n_errors;
  int                 cycles;
  bit                 src_quiet;
  bit                 sink_quiet;

  initial begin
    in_chan.valid    = 1'b0;
    in_chan.x_sample = '0;
    in_chan.y_sample = '0;
    out_chan.ready   = 1'b0;
    cfg_chan.valid   = 1'b0;
    cfg_chan.data    = '0;
  end

  function automatic logic [8:0] heading_of(logic signed [15:0] xs, logic signed [15:0] ys);
    longint x, y, cx, cy, z, nx, ny, h;
    int i;
    x = xs;
    y = ys;
    if (y == 0) return (x < 0) ? 9'd180 : 9'd0;
    if (x == 0) return (y > 0) ? 9'd90 : 9'd270;
    cx = x * 65536;
    cy = y * 65536;
    z  = 0;
    if (x < 0) begin
      if (y > 0) begin
        nx = cy; ny = -cx; z = 90 * 65536;
      end else begin
        nx = -cy; ny = cx; z = -90 * 65536;
      end
      cx = nx;
      cy = ny;
    end
    for (i = 0; i < CORDIC_STEPS && i < 24; i++) begin
      if (cy >= 0) begin
        nx = cx + (cy >>> i);
        ny = cy - (cx >>> i);
        z  = z + ATAN_Q16[i];
      end else begin
        nx = cx - (cy >>> i);
        ny = cy + (cx >>> i);
        z  = z - ATAN_Q16[i];
      end
      cx = nx;
      cy = ny;
    end
    if (y > 0) begin
      h = z >>> 16;
      if (h < 0) h = 0;
      if (h > 179) h = 179;
    end else begin
      h = (z + 360 * 65536) >>> 16;
      if (h < 180) h = 180;
      if (h > 359) h = 359;
    end
    return h[8:0];
  endfunction

  function automatic heading_t predict_heading(logic signed [15:0] xs, logic signed [15:0] ys);
    heading_t r;
    logic signed [15:0] y_eff;
    int h;
    y_eff      = ys + y_off;
    h          = heading_of(xs, y_eff);
    r.heading  = h[8:0];
    r.hundreds = 2'(h / 100);
    r.tens     = 4'((h / 10) % 10);
    r.ones     = 4'(h % 10);
    r.segs     = SEGS_LOW[h % 10];
    return r;
  endfunction

  function automatic int unsigned draw_gap();
    return src_quiet ? 0 : $urandom_range(0, 12);
  endfunction

  function automatic void add_sample(logic signed [15:0] x, logic signed [15:0] y);
    sample_req_t r;
    r.x   = x;
    r.y   = y;
    r.gap = draw_gap();
    sample_q.push_back(r);
  endfunction

  // y_eff is the wanted Y after the offset is added
  function automatic logic signed [15:0] raw_y(logic signed [15:0] y_eff);
    return y_eff - y_off;
  endfunction

  function automatic logic signed [15:0] small_val(int m);
    return 16'($signed($urandom_range(0, 2 * m)) - m);
  endfunction

  function automatic logic signed [15:0] any_val();
    return 16'($urandom_range(0, 65535));
  endfunction

  function automatic logic signed [15:0] edge_val();
    case ($urandom_range(0, 4))
      0: return 16'sh7fff;
      1: return 16'sh8000;
      2: return 16'sh0001;
      3: return 16'shffff;
      default: return 16'sh0000;
    endcase
  endfunction

  function automatic void add_random(int n);
    logic signed [15:0] a, b;
    int k;
    for (k = 0; k < n; k++) begin
      if (k % 80 == 0) src_quiet = ($urandom_range(0, 3) == 0);
      case ($urandom_range(0, 9))
        0, 1, 2, 3: begin
          a = any_val(); b = any_val();
        end
        4: begin
          a = small_val(8); b = raw_y(small_val(8));
        end
        5: begin
          a = 16'sd0; b = any_val();
        end
        6: begin
          a = any_val(); b = raw_y(small_val(2));
        end
        7: begin
          a = small_val(3); b = any_val();
        end
        8: begin
          a = edge_val(); b = raw_y(edge_val());
        end
        default: begin
          a = any_val();
          b = raw_y($urandom_range(0, 1) ? a : -a);
        end
      endcase
      add_sample(a, b);
    end
  endfunction

  task automatic wait_drained();
    do @(negedge clk);
    while (sample_q.size() != 0 || in_chan.valid || heading_q.size() != 0);
  endtask

  task automatic write_y_offset(logic signed [15:0] v);
    @(posedge clk);
    cfg_chan.valid <= 1'b1;
    cfg_chan.data  <= v;
    do @(posedge clk);
    while (!cfg_chan.ready);
    cfg_chan.valid <= 1'b0;
    y_off = v;
    @(negedge clk);
  endtask

  task automatic report_mismatch(string what, int got, int want);
    $display("[%0t] mismatch %s: got %0d, expected %0d", $realtime, what, got, want);
    n_errors++;
  endtask

  // source: one request per queued sample, after its drawn gap
  always @(posedge clk) begin
    if (!rst_n) begin
      in_chan.valid <= 1'b0;
      idle_cnt = 0;
    end else begin
      if (in_chan.valid && in_chan.ready)
        heading_q.push_back(predict_heading(in_chan.x_sample, in_chan.y_sample));
      if (!in_chan.valid || in_chan.ready) begin
        if (sample_q.size() != 0 && idle_cnt >= sample_q[0].gap) begin
          cur_req = sample_q.pop_front();
          in_chan.valid    <= 1'b1;
          in_chan.x_sample <= cur_req.x;
          in_chan.y_sample <= cur_req.y;
          idle_cnt = 0;
        end else begin
          in_chan.valid <= 1'b0;
          if (sample_q.size() != 0) idle_cnt++;
        end
      end
    end
  end

  // sink: check each result, then stall for a drawn number of cycles
  always @(posedge clk) begin
    heading_t want;
    if (!rst_n) begin
      out_chan.ready <= 1'b0;
      stall_left = $urandom_range(0, 12);
    end else begin
      if (out_chan.valid && out_chan.ready) begin
        if (heading_q.size() == 0) begin
          report_mismatch("unexpected result, heading", out_chan.heading_degrees, -1);
        end else begin
          want = heading_q.pop_front();
          if (out_chan.heading_degrees !== want.heading)
            report_mismatch("heading_degrees", out_chan.heading_degrees, want.heading);
          if (out_chan.hundreds_digit !== want.hundreds)
            report_mismatch("hundreds_digit", out_chan.hundreds_digit, want.hundreds);
          if (out_chan.tens_digit !== want.tens)
            report_mismatch("tens_digit", out_chan.tens_digit, want.tens);
          if (out_chan.ones_digit !== want.ones)
            report_mismatch("ones_digit", out_chan.ones_digit, want.ones);
          if (out_chan.segment_pins !== want.segs)
            report_mismatch("segment_pins", out_chan.segment_pins, want.segs);
        end
        n_results++;
        if (n_results % 64 == 0) sink_quiet = ($urandom_range(0, 3) == 0);
        stall_left = sink_quiet ? 0 : $urandom_range(0, 12);
      end
      if (stall_left > 0) begin
        stall_left--;
        out_chan.ready <= 1'b0;
      end else begin
        out_chan.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    logic signed [15:0] offsets [N_PHASES];
    int p;
    offsets = '{16'sh7fff, 16'sh8000, any_val(), any_val(), 16'sd500, 16'shffff};
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset offset of 500 still in force
    add_sample(16'sd0, -16'sd500);
    add_sample(-16'sd1, -16'sd500);
    add_sample(16'sd100, 16'sd0);
    add_sample(16'sd0, -16'sd1000);
    wait_drained();

    write_y_offset(16'sd0);
    add_sample(16'sh7fff, 16'sd0);
    add_sample(16'sh8000, 16'sd0);
    add_sample(16'sd0, 16'sh7fff);
    add_sample(16'sd0, 16'sh8000);
    add_sample(16'sh7fff, 16'sh7fff);
    add_sample(16'sh8000, 16'sh8000);
    add_sample(16'sh7fff, 16'sh8000);
    add_sample(16'sh8000, 16'sh7fff);
    add_sample(16'sd1, 16'sd1);
    add_sample(-16'sd1, 16'sd1);
    add_sample(-16'sd1, -16'sd1);
    add_sample(16'sd1, -16'sd1);
    add_sample(16'sh7fff, 16'sd1);
    add_sample(16'sh7fff, -16'sd1);
    add_sample(16'sh8000, 16'sd1);
    add_sample(16'sh8000, -16'sd1);
    add_sample(16'sd1, 16'sh7fff);
    add_sample(-16'sd1, 16'sh8000);
    add_sample(16'sd3, 16'sd4);
    add_sample(-16'sd5, 16'sd12);
    wait_drained();

    for (p = 0; p < N_PHASES; p++) begin
      write_y_offset(offsets[p]);
      add_random(RANDOM_ITEMS / N_PHASES + 1);
      wait_drained();
      repeat (LATENCY) @(posedge clk);
    end

    if (n_errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
